FILE: src/assert_macros.svh
// Assertion macros shared by the RTL files of the Cholesky factorization unit.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: src/chol_pkg.sv
// Package for the Cholesky factorization unit: widths, defaults and helpers.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package chol_pkg;
   localparam int MaxOrderDefault = 16;
   localparam int FracBitsDefault = 16;
   localparam int DataWidth = 32;
   localparam int AccWidth = 64;
   localparam int IndexWidth = 4;
   localparam int OrderWidth = 5;
   localparam logic [OrderWidth-1:0] OrderReset = 5'd4;

   localparam logic [1:0] OP_SQRT = 2'd0;
   localparam logic [1:0] OP_DIV = 2'd1;

   typedef struct packed {
      logic       start;
      logic [1:0] op;
   } iter_ctl_type;

   typedef struct packed {
      logic                 done;
      logic [DataWidth-1:0] value;
      logic                 flag;
   } iter_sts_type;
endpackage
`default_nettype wire

FILE: src/chol_iter.sv
// Shared iterative unit of the Cholesky unit: one bit a cycle of a square root or a division.
// Depends on chol_pkg; used by cholesky_factorization_unit.
`default_nettype none
`include "assert_macros.svh"
module chol_iter
   import chol_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire iter_ctl_type               ctl,
   input  wire logic signed [AccWidth-1:0] diff,
   input  wire logic signed [DataWidth-1:0] divisor,
   output      iter_sts_type               sts
);
   localparam int CntWidth = 7;
   localparam logic [CntWidth-1:0] DivSteps = 7'd64;
   localparam logic [CntWidth-1:0] SqrtSteps = 7'd32;

   logic                busy_ff, busy_in;
   logic [1:0]          op_ff, op_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic [AccWidth-1:0] num_ff, num_in;
   logic [AccWidth:0]   rem_ff, rem_in;
   logic [AccWidth-1:0] quo_ff, quo_in;
   logic [DataWidth-1:0] den_ff, den_in;
   logic                neg_ff, neg_in;
   logic                flag_ff, flag_in;
   logic                done_ff, done_in;
   logic [DataWidth-1:0] val_ff, val_in;

   logic [AccWidth:0]   trial;
   logic [AccWidth+1:0] rem_sh;
   logic [AccWidth-1:0] mag;
   logic [DataWidth-1:0] dmag;

   always_comb begin
      busy_in = busy_ff;
      op_in = op_ff;
      cnt_in = cnt_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      flag_in = flag_ff;
      done_in = 1'b0;
      val_in = val_ff;
      trial = '0;
      rem_sh = '0;
      mag = diff[AccWidth-1] ? AccWidth'(-diff) : AccWidth'(diff);
      dmag = divisor[DataWidth-1] ? DataWidth'(-divisor) : DataWidth'(divisor);
      if (ctl.start) begin
         op_in = ctl.op;
         num_in = mag;
         rem_in = '0;
         quo_in = '0;
         den_in = dmag;
         neg_in = diff[AccWidth-1] ^ divisor[DataWidth-1];
         flag_in = 1'b0;
         if (ctl.op == OP_SQRT) begin
            cnt_in = SqrtSteps;
            if (diff[AccWidth-1]) begin
               flag_in = 1'b1;
               cnt_in = '0;
            end
         end else begin
            cnt_in = DivSteps;
            if (divisor == '0) begin
               flag_in = 1'b1;
               cnt_in = '0;
            end
         end
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (flag_ff) begin
               val_in = '0;
            end else if (op_ff == OP_SQRT) begin
               val_in = (quo_ff > AccWidth'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                        : quo_ff[DataWidth-1:0];
            end else if (neg_ff) begin
               val_in = (quo_ff >= AccWidth'(32'h8000_0000)) ? 32'h8000_0000
                        : DataWidth'(-quo_ff[DataWidth-1:0]);
            end else begin
               val_in = (quo_ff > AccWidth'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                        : quo_ff[DataWidth-1:0];
            end
         end else begin
            cnt_in = cnt_ff - 1'b1;
            if (op_ff == OP_SQRT) begin
               rem_sh = {rem_ff[AccWidth-1:0], num_ff[AccWidth-1 -: 2]};
               trial = {quo_ff[AccWidth-2:0], 2'b01};
               num_in = {num_ff[AccWidth-3:0], 2'b00};
               if (rem_sh[AccWidth:0] >= trial && rem_sh[AccWidth+1] == 1'b0) begin
                  rem_in = rem_sh[AccWidth:0] - trial;
                  quo_in = {quo_ff[AccWidth-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh[AccWidth:0];
                  quo_in = {quo_ff[AccWidth-2:0], 1'b0};
               end
            end else begin
               rem_sh = {rem_ff, num_ff[AccWidth-1]};
               num_in = {num_ff[AccWidth-2:0], 1'b0};
               if (rem_sh >= (AccWidth+2)'(den_ff)) begin
                  rem_in = rem_sh[AccWidth:0] - (AccWidth+1)'(den_ff);
                  quo_in = {quo_ff[AccWidth-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh[AccWidth:0];
                  quo_in = {quo_ff[AccWidth-2:0], 1'b0};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      op_ff <= op_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      flag_ff <= flag_in;
      val_ff <= val_in;
   end

   assign sts = '{done: done_ff, value: val_ff, flag: flag_ff};

   `ASSERT_NEXT(a_done_after_busy, clock, reset, done_ff, !busy_ff)
   `ASSERT_IMP(a_cnt_bound, clock, reset, busy_ff, cnt_ff <= DivSteps)
   `ASSERT_NEXT(a_start_busy, clock, reset, ctl.start, busy_ff)
endmodule
`default_nettype wire

FILE: src/cholesky_factorization_unit.sv
// Top level of the Cholesky factorization unit: sequencer, factor store, dot product.
// Depends on chol_pkg, chol_iter and assert_macros.svh.
//
//   channel  direction  ports
//   req      in         req_valid, req_stall, req_entry_value
//   rsp      out        rsp_valid, rsp_stall, rsp_row_index .. rsp_last_entry
//   csr      in         csr_write, csr_data
//
// An entry in column j runs j dot-product terms of four steps each (two reads on the single
// store port, one multiply, one add), then a square root or a division in the shared
// bit-serial unit.
// The beat appears in state ST_OUT, before the sequencer returns to idle.
// Reset is synchronous; the factor store is not cleared.
// The result register holds one beat; the next entry is accepted once it is taken.
`default_nettype none
`include "assert_macros.svh"
module cholesky_factorization_unit
   import chol_pkg::*;
#(
   parameter int MAX_ORDER = MaxOrderDefault,
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_stall,
   input  wire logic signed [DataWidth-1:0] req_entry_value,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   output      logic [IndexWidth-1:0]       rsp_row_index,
   output      logic [IndexWidth-1:0]       rsp_col_index,
   output      logic signed [DataWidth-1:0] rsp_factor_value,
   output      logic                        rsp_not_definite,
   output      logic                        rsp_last_entry,
   input  wire logic                        csr_write,
   input  wire logic [OrderWidth-1:0]       csr_data
);
   localparam int Depth = MAX_ORDER * (MAX_ORDER + 1) / 2;
   localparam int AddrWidth = $clog2(Depth);
   localparam int PosWidth = $clog2(MAX_ORDER + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RDA  = 3'd1;
   localparam logic [2:0] ST_RDB  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_ADD  = 3'd4;
   localparam logic [2:0] ST_DIAG = 3'd5;
   localparam logic [2:0] ST_ITER = 3'd6;
   localparam logic [2:0] ST_OUT  = 3'd7;

   logic [DataWidth-1:0] store_mem [Depth];
   logic [DataWidth-1:0] rd_data_ff;
   logic [AddrWidth-1:0] rd_addr;
   logic                 wr_en;
   logic [AddrWidth-1:0] wr_addr;

   logic [2:0]           state_ff, state_in;
   logic [OrderWidth-1:0] order_ff, order_in;
   logic [PosWidth-1:0]  row_ff, row_in, col_ff, col_in, k_ff, k_in;
   logic [AddrWidth-1:0] base_i_ff, base_i_in, base_j_ff, base_j_in;
   logic signed [DataWidth-1:0] a_ff, a_in, la_ff, la_in;
   logic signed [AccWidth-1:0]  prod_ff, prod_in, sum_ff, sum_in, diff_ff, diff_in;
   logic                 out_valid_ff, out_valid_in;
   logic [IndexWidth-1:0] out_row_ff, out_row_in, out_col_ff, out_col_in;
   logic [DataWidth-1:0] out_val_ff, out_val_in;
   logic                 out_flag_ff, out_flag_in, out_last_ff, out_last_in;

   logic [PosWidth-1:0]  eff_n;
   logic [PosWidth-1:0]  row_s, col_s;
   logic signed [AccWidth:0] wide;
   logic signed [AccWidth-1:0] a_scaled;
   iter_ctl_type         ictl;
   iter_sts_type         ists;
   logic                 accept;

   function automatic logic signed [AccWidth-1:0] sat_fit(input logic signed [AccWidth:0] v);
      logic signed [AccWidth-1:0] r;
      r = v[AccWidth-1:0];
      if (v[AccWidth] != v[AccWidth-1]) begin
         r = v[AccWidth] ? {1'b1, {(AccWidth-1){1'b0}}} : {1'b0, {(AccWidth-1){1'b1}}};
      end
      return r;
   endfunction

   always_comb begin
      if (order_ff == '0) begin
         eff_n = PosWidth'(1);
      end else if (32'(order_ff) > MAX_ORDER) begin
         eff_n = PosWidth'(MAX_ORDER);
      end else begin
         eff_n = PosWidth'(order_ff);
      end
   end

   assign req_stall = (state_ff != ST_IDLE) || out_valid_ff;
   assign accept = req_valid && !req_stall;
   assign row_s = (row_ff >= eff_n || col_ff > row_ff) ? '0 : row_ff;
   assign col_s = (row_ff >= eff_n || col_ff > row_ff) ? '0 : col_ff;
   assign a_scaled = AccWidth'(a_ff) <<< FRAC_BITS;

   always_comb begin
      state_in = state_ff;
      order_in = order_ff;
      row_in = row_ff;
      col_in = col_ff;
      k_in = k_ff;
      base_i_in = base_i_ff;
      base_j_in = base_j_ff;
      a_in = a_ff;
      la_in = la_ff;
      prod_in = prod_ff;
      sum_in = sum_ff;
      diff_in = diff_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      out_val_in = out_val_ff;
      out_flag_in = out_flag_ff;
      out_last_in = out_last_ff;
      rd_addr = base_i_ff + AddrWidth'(k_ff);
      wr_en = 1'b0;
      wr_addr = base_i_ff + AddrWidth'(col_ff);
      ictl.start = 1'b0;
      ictl.op = (row_ff == col_ff) ? OP_SQRT : OP_DIV;
      wide = '0;
      case (state_ff)
         ST_IDLE: begin
            if (csr_write) begin
               order_in = csr_data;
               row_in = '0;
               col_in = '0;
            end else if (accept) begin
               row_in = row_s;
               col_in = col_s;
               base_i_in = AddrWidth'(32'(row_s) * (32'(row_s) + 1) / 2);
               base_j_in = AddrWidth'(32'(col_s) * (32'(col_s) + 1) / 2);
               k_in = '0;
               sum_in = '0;
               a_in = req_entry_value;
               state_in = ST_RDA;
            end
         end
         ST_RDA: begin
            if (k_ff == col_ff) begin
               rd_addr = base_j_ff + AddrWidth'(col_ff);
               state_in = ST_DIAG;
            end else begin
               rd_addr = base_i_ff + AddrWidth'(k_ff);
               state_in = ST_RDB;
            end
         end
         ST_RDB: begin
            rd_addr = base_j_ff + AddrWidth'(k_ff);
            la_in = rd_data_ff;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in = AccWidth'(la_ff) * AccWidth'($signed(rd_data_ff));
            state_in = ST_ADD;
         end
         ST_ADD: begin
            wide = {sum_ff[AccWidth-1], sum_ff} + {prod_ff[AccWidth-1], prod_ff};
            sum_in = sat_fit(wide);
            k_in = k_ff + 1'b1;
            state_in = ST_RDA;
         end
         ST_DIAG: begin
            wide = {a_scaled[AccWidth-1], a_scaled} - {sum_ff[AccWidth-1], sum_ff};
            diff_in = sat_fit(wide);
            ictl.start = 1'b1;
            state_in = ST_ITER;
         end
         ST_ITER: begin
            if (ists.done) begin
               wr_en = 1'b1;
               out_valid_in = 1'b1;
               out_row_in = IndexWidth'(row_ff);
               out_col_in = IndexWidth'(col_ff);
               out_val_in = ists.value;
               out_flag_in = ists.flag;
               out_last_in = 1'b0;
               if (row_ff == col_ff) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
                  if (row_ff + 1'b1 >= eff_n) begin
                     row_in = '0;
                     out_last_in = 1'b1;
                  end
               end else begin
                  col_in = col_ff + 1'b1;
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= ists.value;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         order_ff <= OrderReset;
         row_ff <= '0;
         col_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         order_ff <= order_in;
         row_ff <= row_in;
         col_ff <= col_in;
         out_valid_ff <= out_valid_in;
      end
      k_ff <= k_in;
      base_i_ff <= base_i_in;
      base_j_ff <= base_j_in;
      a_ff <= a_in;
      la_ff <= la_in;
      prod_ff <= prod_in;
      sum_ff <= sum_in;
      diff_ff <= diff_in;
      out_row_ff <= out_row_in;
      out_col_ff <= out_col_in;
      out_val_ff <= out_val_in;
      out_flag_ff <= out_flag_in;
      out_last_ff <= out_last_in;
   end

   chol_iter u_iter (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ictl),
      .diff    (diff_in),
      .divisor (rd_data_ff),
      .sts     (ists)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_row_index = out_row_ff;
   assign rsp_col_index = out_col_ff;
   assign rsp_factor_value = out_val_ff;
   assign rsp_not_definite = out_flag_ff;
   assign rsp_last_entry = out_last_ff;

   `ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, req_stall)
   `ASSERT_NEXT(a_done_gives_beat, clock, reset, state_ff == ST_ITER && ists.done, rsp_valid)
   `ASSERT_IMP(a_col_le_row, clock, reset, state_ff != ST_IDLE, col_ff <= row_ff)
   `ASSERT_IMP(a_k_le_col, clock, reset, state_ff == ST_RDA, k_ff <= col_ff)
endmodule
`default_nettype wire
